// ===== sv/s5hs_pkg.sv =====
// Shared types and codes for the SOCKS5 handshake parser.
package s5hs_pkg;

  // Parse stage of the client byte stream
  typedef enum logic [3:0] {
    ST_GVER    = 4'd0,
    ST_NMETH   = 4'd1,
    ST_METHODS = 4'd2,
    ST_RVER    = 4'd3,
    ST_RCMD    = 4'd4,
    ST_RRSV    = 4'd5,
    ST_RATYP   = 4'd6,
    ST_DLEN    = 4'd7,
    ST_ADDR    = 4'd8,
    ST_PORTHI  = 4'd9,
    ST_PORTLO  = 4'd10,
    ST_STREAM  = 4'd11,
    ST_CLOSED  = 4'd12
  } stage_t;

  // Event reported with each transaction
  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_METHOD   = 4'd1,
    EV_NOMETHOD = 4'd2,
    EV_BADVER   = 4'd3,
    EV_BADATYP  = 4'd4,
    EV_BADCMD   = 4'd5,
    EV_ADDR     = 4'd6,
    EV_DONE     = 4'd7,
    EV_STREAM   = 4'd8,
    EV_CLOSED   = 4'd9
  } event_t;

  // Protocol byte values
  localparam logic [7:0] SOCKS_VER    = 8'h05;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;
  localparam logic [7:0] METH_NOAUTH  = 8'h00;
  localparam logic [7:0] METH_NONE    = 8'hFF;
  localparam logic [7:0] LEN_IPV4     = 8'd4;
  localparam logic [7:0] LEN_IPV6     = 8'd16;

  // Destination kind codes
  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_DOMAIN  = 2'd1;
  localparam logic [1:0] KIND_IPV6    = 2'd2;

  // One result transaction
  typedef struct packed {
    event_t      ev;
    logic [7:0]  out_byte;
    logic [1:0]  addr_kind;
    logic [7:0]  addr_index;
    logic [15:0] dest_port;
  } res_t;

endpackage

// ===== sv/s5hs_core.sv =====
// Handshake state registers and the per-byte parse step.
module s5hs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    data_byte,
  input  logic          end_of_stream,
  output s5hs_pkg::res_t res
);
  import s5hs_pkg::*;

  stage_t     stage, stage_next;
  logic [7:0] byte_counter, byte_counter_next;
  logic [7:0] methods_left, methods_left_next;
  logic       noauth_seen, noauth_seen_next;
  logic [1:0] dest_kind, dest_kind_next;
  logic [7:0] addr_length, addr_length_next;
  logic [7:0] port_high, port_high_next;

  logic [7:0] methods_dec;
  logic [7:0] counter_inc;
  logic       seen_now;

  assign methods_dec = methods_left - 8'd1;
  assign counter_inc = byte_counter + 8'd1;
  assign seen_now    = noauth_seen | (data_byte == METH_NOAUTH);

  // Next state for one accepted byte
  always_comb begin
    stage_next        = stage;
    byte_counter_next = byte_counter;
    methods_left_next = methods_left;
    noauth_seen_next  = noauth_seen;
    dest_kind_next    = dest_kind;
    addr_length_next  = addr_length;
    port_high_next    = port_high;
    if (end_of_stream) begin
      stage_next = ST_CLOSED;
    end else begin
      case (stage)
        ST_GVER: begin
          stage_next = (data_byte == SOCKS_VER) ? ST_NMETH : ST_CLOSED;
        end
        ST_NMETH: begin
          methods_left_next = data_byte;
          noauth_seen_next  = 1'b0;
          stage_next = (data_byte == 8'd0) ? ST_CLOSED : ST_METHODS;
        end
        ST_METHODS: begin
          methods_left_next = methods_dec;
          noauth_seen_next  = seen_now;
          if (methods_dec == 8'd0) begin
            stage_next = seen_now ? ST_RVER : ST_CLOSED;
          end
        end
        ST_RVER: begin
          stage_next = (data_byte == SOCKS_VER) ? ST_RCMD : ST_CLOSED;
        end
        ST_RCMD: begin
          stage_next = (data_byte == CMD_CONNECT) ? ST_RRSV : ST_CLOSED;
        end
        ST_RRSV: begin
          stage_next = ST_RATYP;
        end
        ST_RATYP: begin
          case (data_byte)
            ATYP_IPV4: begin
              dest_kind_next    = KIND_IPV4;
              addr_length_next  = LEN_IPV4;
              byte_counter_next = 8'd0;
              stage_next        = ST_ADDR;
            end
            ATYP_IPV6: begin
              dest_kind_next    = KIND_IPV6;
              addr_length_next  = LEN_IPV6;
              byte_counter_next = 8'd0;
              stage_next        = ST_ADDR;
            end
            ATYP_DOMAIN: begin
              dest_kind_next = KIND_DOMAIN;
              stage_next     = ST_DLEN;
            end
            default: begin
              stage_next = ST_CLOSED;
            end
          endcase
        end
        ST_DLEN: begin
          dest_kind_next    = KIND_DOMAIN;
          addr_length_next  = data_byte;
          byte_counter_next = 8'd0;
          stage_next = (data_byte == 8'd0) ? ST_PORTHI : ST_ADDR;
        end
        ST_ADDR: begin
          byte_counter_next = counter_inc;
          if (counter_inc == addr_length) begin
            stage_next = ST_PORTHI;
          end
        end
        ST_PORTHI: begin
          port_high_next = data_byte;
          stage_next     = ST_PORTLO;
        end
        ST_PORTLO: begin
          stage_next = ST_STREAM;
        end
        default: begin
        end
      endcase
    end
  end

  // Result for one accepted byte
  always_comb begin
    res = '{ev: EV_NONE, out_byte: 8'd0, addr_kind: 2'd0,
            addr_index: 8'd0, dest_port: 16'd0};
    if (end_of_stream) begin
      if (stage != ST_CLOSED) begin
        res.ev = EV_CLOSED;
      end
    end else begin
      case (stage)
        ST_GVER, ST_RVER: begin
          if (data_byte != SOCKS_VER) begin
            res.ev = EV_BADVER;
          end
        end
        ST_NMETH: begin
          if (data_byte == 8'd0) begin
            res.ev       = EV_NOMETHOD;
            res.out_byte = METH_NONE;
          end
        end
        ST_METHODS: begin
          if (methods_dec == 8'd0) begin
            res.ev       = seen_now ? EV_METHOD : EV_NOMETHOD;
            res.out_byte = seen_now ? METH_NOAUTH : METH_NONE;
          end
        end
        ST_RCMD: begin
          if (data_byte != CMD_CONNECT) begin
            res.ev = EV_BADCMD;
          end
        end
        ST_RATYP: begin
          if (data_byte != ATYP_IPV4 && data_byte != ATYP_IPV6 &&
              data_byte != ATYP_DOMAIN) begin
            res.ev = EV_BADATYP;
          end
        end
        ST_ADDR: begin
          res.ev         = EV_ADDR;
          res.out_byte   = data_byte;
          res.addr_kind  = dest_kind;
          res.addr_index = byte_counter;
        end
        ST_PORTLO: begin
          res.ev        = EV_DONE;
          res.addr_kind = dest_kind;
          res.dest_port = {port_high, data_byte};
        end
        ST_STREAM: begin
          res.ev       = EV_STREAM;
          res.out_byte = data_byte;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= ST_GVER;
      byte_counter <= 8'd0;
      methods_left <= 8'd0;
      noauth_seen  <= 1'b0;
      dest_kind    <= 2'd0;
      addr_length  <= 8'd0;
      port_high    <= 8'd0;
    end else if (fire) begin
      stage        <= stage_next;
      byte_counter <= byte_counter_next;
      methods_left <= methods_left_next;
      noauth_seen  <= noauth_seen_next;
      dest_kind    <= dest_kind_next;
      addr_length  <= addr_length_next;
      port_high    <= port_high_next;
    end
  end

  // A closed session stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    stage == ST_CLOSED |=> stage == ST_CLOSED)
    else $error("session left the closed stage");

  // Address byte position stays below the address length
  a_addr_bound: assert property (@(posedge clk) disable iff (rst)
    stage == ST_ADDR |-> byte_counter < addr_length)
    else $error("address byte counter overran the length");

  // Stream stage only leaves for close
  a_stream_exit: assert property (@(posedge clk) disable iff (rst)
    stage == ST_STREAM |=> stage == ST_STREAM || stage == ST_CLOSED)
    else $error("stream stage left without close");

  // Stream bytes are reported only from the stream stage
  a_stream_event: assert property (@(posedge clk) disable iff (rst)
    fire && res.ev == EV_STREAM |-> stage == ST_STREAM && !end_of_stream)
    else $error("stream event outside stream stage");

endmodule

// ===== sv/s5hs_obuf.sv =====
// Two-entry result buffer between the parse step and the output channel.
module s5hs_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  s5hs_pkg::res_t push_res,
  output logic           has_room,
  output logic           head_valid,
  input  logic           pop,
  output s5hs_pkg::res_t head_res
);
  import s5hs_pkg::*;

  logic [1:0] count, count_next;
  res_t       slot0;
  res_t       slot1;

  assign has_room   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_res   = slot0;

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Move payload: fill head, spill to second slot, shift on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= push_res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_res;
      end else begin
        slot1 <= push_res;
      end
    end
  end

endmodule

// ===== sv/socks5_handshake_parser.sv =====
// Top level of the byte-serial SOCKS5 server handshake parser.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one client byte per transaction
//   with end_of_stream marking peer close. Every accepted byte gives exactly
//   one result transaction on the output channel (out_valid/out_ready):
//   event_res, out_byte, addr_kind, addr_index and dest_port.
//   A byte accepted is registered in the result buffer and is presented
//   once the results ahead of it are taken. Throughput is one byte per
//   cycle while the buffer has a free entry; the parse step is a single pass
//   of logic from the session state registers into a two-entry result buffer.
//   in_ready is high while the buffer has a free entry, so a byte is taken
//   even while an earlier result waits. If the receiver stalls, up to two
//   results are held and in_ready drops until one is taken.
//   Reset puts the session in the greeting version stage and empties the
//   result buffer; no clearing pass is needed.
module socks5_handshake_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic [7:0]  out_byte,
  output logic [1:0]  addr_kind,
  output logic [7:0]  addr_index,
  output logic [15:0] dest_port
);
  import s5hs_pkg::*;

  logic fire;
  logic room;
  res_t step_res;
  res_t head_res;

  assign in_ready = room;
  assign fire     = in_valid && room;

  // Parse one byte per accepted transaction
  s5hs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .res           (step_res)
  );

  // Hold results for the receiver
  s5hs_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .push_res   (step_res),
    .has_room   (room),
    .head_valid (out_valid),
    .pop        (out_valid && out_ready),
    .head_res   (head_res)
  );

  // Drive result fields
  assign event_res  = head_res.ev;
  assign out_byte   = head_res.out_byte;
  assign addr_kind  = head_res.addr_kind;
  assign addr_index = head_res.addr_index;
  assign dest_port  = head_res.dest_port;

endmodule

// ===== test/socks5_handshake_parser_tb.sv =====
// Self-checking testbench for the byte-serial SOCKS5 server handshake parser.
module socks5_handshake_parser_tb;
  import s5hs_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_res;
  logic [7:0]  out_byte;
  logic [1:0]  addr_kind;
  logic [7:0]  addr_index;
  logic [15:0] dest_port;

  // Percentages of cycles in which the client idles and the receiver stalls
  int gap_pct = 0;
  int stall_pct = 0;

  int error_count = 0;
  int idle_cycles = 0;

  // Session state of the predictor
  stage_t     sess_stage = ST_GVER;
  logic [7:0] sess_count = 8'd0;
  logic [7:0] sess_methods = 8'd0;
  logic       sess_noauth = 1'b0;
  logic [1:0] sess_kind = 2'd0;
  logic [7:0] sess_addr_len = 8'd0;
  logic [7:0] sess_port_hi = 8'd0;

  res_t predicted_results[$];

  socks5_handshake_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .out_byte      (out_byte),
    .addr_kind     (addr_kind),
    .addr_index    (addr_index),
    .dest_port     (dest_port)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the session by one client byte and queue the result it gives
  task automatic parse_client_byte(input logic [7:0] b, input logic eos);
    res_t r;
    r = '{ev: EV_NONE, out_byte: 8'h00, addr_kind: 2'd0, addr_index: 8'd0,
          dest_port: 16'd0};
    if (eos) begin
      if (sess_stage != ST_CLOSED) begin
        r.ev = EV_CLOSED;
        sess_stage = ST_CLOSED;
      end
    end else begin
      case (sess_stage)
        ST_GVER: begin
          if (b != SOCKS_VER) begin
            r.ev = EV_BADVER;
            sess_stage = ST_CLOSED;
          end else begin
            sess_stage = ST_NMETH;
          end
        end
        ST_NMETH: begin
          sess_methods = b;
          sess_noauth = 1'b0;
          if (b == 8'd0) begin
            r.ev = EV_NOMETHOD;
            r.out_byte = METH_NONE;
            sess_stage = ST_CLOSED;
          end else begin
            sess_stage = ST_METHODS;
          end
        end
        ST_METHODS: begin
          if (b == METH_NOAUTH) sess_noauth = 1'b1;
          sess_methods = sess_methods - 8'd1;
          if (sess_methods == 8'd0) begin
            if (sess_noauth) begin
              r.ev = EV_METHOD;
              r.out_byte = METH_NOAUTH;
              sess_stage = ST_RVER;
            end else begin
              r.ev = EV_NOMETHOD;
              r.out_byte = METH_NONE;
              sess_stage = ST_CLOSED;
            end
          end
        end
        ST_RVER: begin
          if (b != SOCKS_VER) begin
            r.ev = EV_BADVER;
            sess_stage = ST_CLOSED;
          end else begin
            sess_stage = ST_RCMD;
          end
        end
        ST_RCMD: begin
          if (b != CMD_CONNECT) begin
            r.ev = EV_BADCMD;
            sess_stage = ST_CLOSED;
          end else begin
            sess_stage = ST_RRSV;
          end
        end
        ST_RRSV: sess_stage = ST_RATYP;
        ST_RATYP: begin
          sess_count = 8'd0;
          if (b == ATYP_IPV4) begin
            sess_kind = KIND_IPV4;
            sess_addr_len = LEN_IPV4;
            sess_stage = ST_ADDR;
          end else if (b == ATYP_IPV6) begin
            sess_kind = KIND_IPV6;
            sess_addr_len = LEN_IPV6;
            sess_stage = ST_ADDR;
          end else if (b == ATYP_DOMAIN) begin
            sess_kind = KIND_DOMAIN;
            sess_stage = ST_DLEN;
          end else begin
            r.ev = EV_BADATYP;
            sess_stage = ST_CLOSED;
          end
        end
        ST_DLEN: begin
          sess_kind = KIND_DOMAIN;
          sess_addr_len = b;
          sess_count = 8'd0;
          // An empty domain skips straight to the port
          sess_stage = (b == 8'd0) ? ST_PORTHI : ST_ADDR;
        end
        ST_ADDR: begin
          r.ev = EV_ADDR;
          r.out_byte = b;
          r.addr_kind = sess_kind;
          r.addr_index = sess_count;
          sess_count = sess_count + 8'd1;
          if (sess_count == sess_addr_len) sess_stage = ST_PORTHI;
        end
        ST_PORTHI: begin
          sess_port_hi = b;
          sess_stage = ST_PORTLO;
        end
        ST_PORTLO: begin
          r.ev = EV_DONE;
          r.addr_kind = sess_kind;
          r.dest_port = {sess_port_hi, b};
          sess_stage = ST_STREAM;
        end
        ST_STREAM: begin
          r.ev = EV_STREAM;
          r.out_byte = b;
        end
        default: ;
      endcase
    end
    predicted_results.push_back(r);
  endtask

  // Check each result taken, then predict from each byte taken
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: event_res %0d", event_res);
          error_count++;
        end else begin
          exp_res = predicted_results.pop_front();
          if (event_res != exp_res.ev) begin
            $error("event_res: expected %0d, actual %0d", exp_res.ev, event_res);
            error_count++;
          end
          if (out_byte != exp_res.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", exp_res.out_byte, out_byte);
            error_count++;
          end
          if (addr_kind != exp_res.addr_kind) begin
            $error("addr_kind: expected %0d, actual %0d", exp_res.addr_kind, addr_kind);
            error_count++;
          end
          if (addr_index != exp_res.addr_index) begin
            $error("addr_index: expected %0d, actual %0d", exp_res.addr_index,
                   addr_index);
            error_count++;
          end
          if (dest_port != exp_res.dest_port) begin
            $error("dest_port: expected %0d, actual %0d", exp_res.dest_port, dest_port);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_client_byte(data_byte, end_of_stream);
    end
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("socks5_handshake_parser: mismatch");
        $finish;
      end
    end
  end

  // Offer one client byte and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  // Greeting: three methods with no authentication in the middle
  task automatic test_greeting();
    gap_pct = 0;
    stall_pct = 0;
    send_byte(SOCKS_VER, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(METH_NONE, 1'b0);
    send_byte(METH_NOAUTH, 1'b0);
    send_byte(8'h02, 1'b0);
  endtask

  // Connect request to a randomly chosen kind of destination
  task automatic test_request();
    int         pick;
    logic [7:0] dlen;
    gap_pct = 73;
    stall_pct = 0;
    send_byte(SOCKS_VER, 1'b0);
    send_byte(CMD_CONNECT, 1'b0);
    send_byte(8'($urandom), 1'b0);
    case ($urandom_range(0, 2))
      0: begin
        send_byte(ATYP_IPV4, 1'b0);
        repeat (LEN_IPV4) send_byte(8'($urandom), 1'b0);
      end
      1: begin
        send_byte(ATYP_IPV6, 1'b0);
        repeat (LEN_IPV6) send_byte(8'($urandom), 1'b0);
      end
      default: begin
        pick = $urandom_range(0, 9);
        dlen = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 24));
        send_byte(ATYP_DOMAIN, 1'b0);
        send_byte(dlen, 1'b0);
        repeat (dlen) send_byte(8'($urandom), 1'b0);
      end
    endcase
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
  endtask

  // Stream data: byte extremes and alternating bit patterns
  task automatic test_stream_patterns();
    gap_pct = 0;
    stall_pct = 73;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
  endtask

  // Stream data at random under each mix of idling and stalling
  task automatic test_stream_random();
    int gaps[5] = '{0, 73, 0, 34, 0};
    int stalls[5] = '{0, 0, 73, 34, 0};
    for (int p = 0; p < 5; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      repeat (80) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Peer closes, then the session ignores whatever follows
  task automatic test_close();
    gap_pct = 34;
    stall_pct = 34;
    send_byte(8'($urandom), 1'b1);
    repeat (12) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_greeting();
    test_request();
    test_stream_patterns();
    test_stream_random();
    test_close();
    // Let the last byte be predicted, drain results, then wait out the latency
    do @(posedge clk); while (predicted_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("socks5_handshake_parser: match");
    end else begin
      $display("socks5_handshake_parser: mismatch");
    end
    $finish;
  end

endmodule
